// ----- design/msp_pkg.sv -----
`default_nettype none

package msp_pkg;

  // Field and datapath widths
  localparam int EncW     = 21;
  localparam int TargetW  = 21;
  localparam int GainW    = 24;
  localparam int DriveW   = 16;
  localparam int DutyW    = 15;
  localparam int ErrW     = 22;
  localparam int IntW     = 25;
  localparam int DerW     = 23;
  localparam int TmpW     = 28;
  localparam int AccW     = 52;
  localparam int MulW     = 32;
  localparam int ProdW    = 64;
  localparam int PartW    = 48;   // product magnitude bound for the PID terms

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CFG_TARGET    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_P    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_I    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_D    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INT_LIMIT = 3'd4;
  localparam logic [GainW-1:0]   IntLimitReset = 24'hFF_FFFF;

  // Drive band
  localparam int DeadbandPercent = 40;
  localparam int FullPercent     = 100;

  // Divide by ten: x / 10 == (x * Magic10) >> Div10Shift for any 32 bit x
  localparam logic [MulW-1:0] Magic10    = 32'hCCCC_CCCD;
  localparam int              Div10Shift = 35;

  // Sequencer
  localparam int NumSteps = 10;
  localparam int StepW    = 4;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DERIV,
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_DRIVE
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_TGT_ZERO,
    COND_OUT_FULL
  } cond_t;

  // One microcode control word
  typedef struct packed {
    cond_t    cond;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     ld_err;
    logic     ld_int;
    logic     ld_deriv;
    logic     ld_n;
    logic     ld_drive;
    logic     last;
  } uword_t;

  typedef struct packed {
    logic   fire;
    uword_t uw;
  } ctrl_t;

  typedef struct packed {
    logic tgt_zero;
    logic out_full;
  } seq_stat_t;

endpackage

`default_nettype wire

// ----- design/msp_if.sv -----
`default_nettype none

// Input word channel
interface msp_in_if;
  import msp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [EncW-1:0] encoder_rate;

  modport source (output valid, output encoder_rate, input ready);
  modport sink   (input valid, input encoder_rate, output ready);
endinterface

// Result word channel
interface msp_out_if;
  import msp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive_q8;
  logic        [DutyW-1:0]  duty_fwd_q8;
  logic        [DutyW-1:0]  duty_rev_q8;

  modport source (output valid, output drive_q8, output duty_fwd_q8, output duty_rev_q8,
                  input ready);
  modport sink   (input valid, input drive_q8, input duty_fwd_q8, input duty_rev_q8,
                  output ready);
endinterface

`default_nettype wire

// ----- design/msp_useq.sv -----
`default_nettype none

module msp_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  msp_pkg::seq_stat_t stat,
  output logic               busy,
  output msp_pkg::ctrl_t     ctrl
);
  import msp_pkg::*;

  // Program ROM: one control word per step
  function automatic uword_t rom(input logic [StepW-1:0] addr);
    uword_t w;
    w = '0;
    w.cond    = COND_NONE;
    w.mul_sel = MUL_NONE;
    w.acc_op  = ACC_HOLD;
    unique case (addr)
      4'd0: begin  // error; leave at once on a zero target
        w.ld_err = 1'b1;
        w.cond   = COND_TGT_ZERO;
      end
      4'd1: w.ld_int = 1'b1;             // integral clamp, 9*raw + old derivative
      4'd2: w.mul_sel = MUL_DERIV;       // divide by ten
      4'd3: begin
        w.ld_deriv = 1'b1;
        w.mul_sel  = MUL_P;
      end
      4'd4: begin
        w.acc_op  = ACC_LOAD;
        w.mul_sel = MUL_I;
      end
      4'd5: begin
        w.acc_op  = ACC_ADD;
        w.mul_sel = MUL_D;
      end
      4'd6: w.acc_op = ACC_ADD;
      4'd7: w.ld_n = 1'b1;               // band clamp, 7*old + 3*new
      4'd8: w.mul_sel = MUL_DRIVE;       // rounded divide by ten
      4'd9: begin                        // commit drive; wait on a full output
        w.ld_drive = 1'b1;
        w.last     = 1'b1;
        w.cond     = COND_OUT_FULL;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  logic             busy_r, busy_nxt;
  logic [StepW-1:0] pc_r, pc_nxt;
  uword_t           uw;
  logic             hold;
  logic             leave;

  always_comb begin
    uw    = rom(pc_r);
    hold  = (uw.cond == COND_OUT_FULL) && stat.out_full;
    leave = uw.last || ((uw.cond == COND_TGT_ZERO) && stat.tgt_zero);
  end

  // Step counter next value
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    priority if (!busy_r) begin
      busy_nxt = start;
      pc_nxt   = '0;
    end else if (hold) begin
      pc_nxt = pc_r;
    end else if (leave) begin
      busy_nxt = 1'b0;
      pc_nxt   = '0;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  // Control out
  always_comb begin
    busy      = busy_r;
    ctrl.fire = busy_r && !hold;
    ctrl.uw   = uw;
  end

endmodule

`default_nettype wire

// ----- design/motor_speed_pid_controller_top.sv -----
// Motor speed PID controller with drive smoothing.
// in_chan carries one encoder_rate word per control tick; out_chan returns
// drive_q8 and the two half-bridge duties. Both are valid/ready channels.
// cfg_we/cfg_idx/cfg_data write target, gains and integral limit; write only
// while idle. Writing the target clears the integral and the last error.
// Each word runs a ten-step microprogram over one shared 32x32 multiplier;
// ready is low while the program runs, so a new word is taken only once
// the last one is done. A zero-target word is consumed and gives no result.
// A result waits in the output register; if it is still not taken when the
// next one is done, the program holds on its last step until out ready.
// Reset clears all controller state, the gains and the target, sets the
// integral limit to its maximum and empties the output register.
`default_nettype none

module motor_speed_pid_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  msp_in_if.sink                         in_chan,
  msp_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [msp_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [msp_pkg::CfgDataW-1:0]   cfg_data
);
  import msp_pkg::*;

  localparam logic signed [AccW-1:0] BandLo = AccW'(DeadbandPercent * 65536);
  localparam logic signed [AccW-1:0] BandHi = AccW'(FullPercent * 65536);

  // Configuration registers
  logic signed [TargetW-1:0] target_r;
  logic [GainW-1:0]          gain_p_r, gain_i_r, gain_d_r, int_limit_r;

  // Controller state and working registers
  logic signed [EncW-1:0]   enc_r;
  logic signed [ErrW-1:0]   err_r, prev_err_r;
  logic signed [IntW-1:0]   error_integral_r;
  logic signed [DerW-1:0]   sd_r;
  logic signed [DriveW-1:0] prev_drive_r;
  logic signed [TmpW-1:0]   tmp_r;
  logic [ProdW-1:0]         prod_r;
  logic                     prod_neg_r;
  logic signed [AccW-1:0]   acc_r;

  // Output register
  logic                     out_valid_r;
  logic signed [DriveW-1:0] out_drive_r;
  logic [DutyW-1:0]         out_fwd_r, out_rev_r;

  logic      busy, start;
  ctrl_t     ctrl;
  seq_stat_t stat;

  assign start         = in_chan.valid && in_chan.ready;
  assign in_chan.ready = rst_n && !busy;
  assign stat.tgt_zero = (target_r == '0);
  assign stat.out_full = out_valid_r && !out_chan.ready;

  msp_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  logic tgt_pos;
  assign tgt_pos = !target_r[TargetW-1];

  // Magnitudes for the multiplier
  logic [ErrW-1:0] err_abs;
  logic [IntW-1:0] int_abs;
  logic [DerW-1:0] sd_abs;
  logic [TmpW-1:0] tmp_abs;
  always_comb begin
    err_abs = err_r[ErrW-1]            ? ErrW'(-err_r)            : ErrW'(err_r);
    int_abs = error_integral_r[IntW-1] ? IntW'(-error_integral_r) : IntW'(error_integral_r);
    sd_abs  = sd_r[DerW-1]             ? DerW'(-sd_r)             : DerW'(sd_r);
    tmp_abs = tmp_r[TmpW-1]            ? TmpW'(-tmp_r)            : TmpW'(tmp_r);
  end

  // Operand selection
  logic [MulW-1:0] mul_a, mul_b;
  logic            mul_neg;
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (ctrl.uw.mul_sel)
      MUL_DERIV: begin
        mul_a   = MulW'(tmp_abs);
        mul_b   = Magic10;
        mul_neg = tmp_r[TmpW-1];
      end
      MUL_P: begin
        mul_a   = MulW'(err_abs);
        mul_b   = MulW'(gain_p_r);
        mul_neg = err_r[ErrW-1];
      end
      MUL_I: begin
        mul_a   = MulW'(int_abs);
        mul_b   = MulW'(gain_i_r);
        mul_neg = error_integral_r[IntW-1];
      end
      MUL_D: begin
        mul_a   = MulW'(sd_abs);
        mul_b   = MulW'(gain_d_r);
        mul_neg = sd_r[DerW-1];
      end
      MUL_DRIVE: begin
        mul_a   = MulW'(tmp_abs) + MulW'(5);
        mul_b   = Magic10;
        mul_neg = tmp_r[TmpW-1];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  // Integral update with sign-dependent clamp
  logic signed [IntW:0] int_sum, int_lim;
  logic signed [IntW:0] int_clamped;
  always_comb begin
    int_sum = {error_integral_r[IntW-1], error_integral_r}
            + {{(IntW+1-ErrW){err_r[ErrW-1]}}, err_r};
    int_lim = {2'b00, int_limit_r};
    int_clamped = int_sum;
    if (tgt_pos) begin
      if (int_sum < 0)            int_clamped = '0;
      else if (int_sum > int_lim) int_clamped = int_lim;
    end else begin
      if (int_sum > 0)             int_clamped = '0;
      else if (int_sum < -int_lim) int_clamped = -int_lim;
    end
  end

  // 9*raw + old smoothed derivative
  logic signed [DerW-1:0] raw;
  logic signed [TmpW-1:0] raw_x, deriv_num;
  always_comb begin
    raw       = {err_r[ErrW-1], err_r} - {prev_err_r[ErrW-1], prev_err_r};
    raw_x     = {{(TmpW-DerW){raw[DerW-1]}}, raw};
    deriv_num = (raw_x <<< 3) + raw_x + {{(TmpW-DerW){sd_r[DerW-1]}}, sd_r};
  end

  // Quotients by ten
  logic [DerW-1:0]   q_deriv;
  logic [DriveW-1:0] q_drive;
  logic              q_drive_nz;
  always_comb begin
    q_deriv    = prod_r[Div10Shift +: DerW];
    q_drive    = prod_r[Div10Shift +: DriveW];
    q_drive_nz = (q_drive != '0);
  end

  // Signed product for the PID sum
  logic signed [AccW-1:0] prod_s;
  always_comb begin
    prod_s = prod_neg_r ? -$signed({{(AccW-PartW){1'b0}}, prod_r[PartW-1:0]})
                        :  $signed({{(AccW-PartW){1'b0}}, prod_r[PartW-1:0]});
  end

  // Drive band clamp, Q8 truncation, 7*old + 3*new
  logic signed [AccW-1:0] c16;
  logic signed [23:0]     c16_adj;
  logic signed [DriveW-1:0] c8;
  logic signed [19:0]     c8_x, pd_x, n_mix;
  always_comb begin
    c16 = acc_r;
    if (tgt_pos) begin
      if (acc_r < BandLo)      c16 = BandLo;
      else if (acc_r > BandHi) c16 = BandHi;
    end else begin
      if (acc_r < -BandHi)      c16 = -BandHi;
      else if (acc_r > -BandLo) c16 = -BandLo;
    end
    c16_adj = c16[23:0] + (c16[AccW-1] ? 24'sd255 : 24'sd0);
    c8      = c16_adj[23:8];
    c8_x    = {{4{c8[DriveW-1]}}, c8};
    pd_x    = {{4{prev_drive_r[DriveW-1]}}, prev_drive_r};
    n_mix   = (pd_x <<< 3) - pd_x + (c8_x <<< 1) + c8_x;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      int_limit_r <= IntLimitReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TARGET:    target_r    <= cfg_data[TargetW-1:0];
        CFG_GAIN_P:    gain_p_r    <= cfg_data[GainW-1:0];
        CFG_GAIN_I:    gain_i_r    <= cfg_data[GainW-1:0];
        CFG_GAIN_D:    gain_d_r    <= cfg_data[GainW-1:0];
        CFG_INT_LIMIT: int_limit_r <= cfg_data[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_integral_r <= '0;
      prev_err_r       <= '0;
      sd_r             <= '0;
      prev_drive_r     <= '0;
    end else if (cfg_we && (cfg_idx == CFG_TARGET)) begin
      error_integral_r <= '0;
      prev_err_r       <= '0;
    end else if (ctrl.fire) begin
      if (ctrl.uw.ld_int) begin
        error_integral_r <= int_clamped[IntW-1:0];
        prev_err_r       <= err_r;
      end
      if (ctrl.uw.ld_deriv)
        sd_r <= prod_neg_r ? DerW'(-$signed(q_deriv)) : $signed(q_deriv);
      if (ctrl.uw.ld_drive)
        prev_drive_r <= prod_neg_r ? DriveW'(-$signed(q_drive)) : $signed(q_drive);
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (start)
      enc_r <= in_chan.encoder_rate;
    if (ctrl.fire) begin
      prod_r     <= mul_a * mul_b;
      prod_neg_r <= mul_neg;
      if (ctrl.uw.ld_err)
        err_r <= {target_r[TargetW-1], target_r} + {enc_r[EncW-1], enc_r};
      if (ctrl.uw.ld_int)
        tmp_r <= deriv_num;
      if (ctrl.uw.ld_n)
        tmp_r <= {{(TmpW-20){n_mix[19]}}, n_mix};
      unique case (ctrl.uw.acc_op)
        ACC_LOAD: acc_r <= prod_s;
        ACC_ADD:  acc_r <= acc_r + prod_s;
        default:  acc_r <= acc_r;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fire && ctrl.uw.ld_drive) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.uw.ld_drive) begin
      out_drive_r <= prod_neg_r ? DriveW'(-$signed(q_drive)) : $signed(q_drive);
      out_fwd_r   <= (!prod_neg_r && q_drive_nz) ? q_drive[DutyW-1:0] : '0;
      out_rev_r   <= ( prod_neg_r && q_drive_nz) ? q_drive[DutyW-1:0] : '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.drive_q8    = out_drive_r;
  assign out_chan.duty_fwd_q8 = out_fwd_r;
  assign out_chan.duty_rev_q8 = out_rev_r;

  // Checks
  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.fire && ctrl.uw.ld_drive))
    else $error("result word appeared without a commit step");

  a_one_bridge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fwd_r == '0) || (out_rev_r == '0))
    else $error("both bridge duties nonzero");

  a_fwd_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_drive_r[DriveW-1]) |-> (out_fwd_r == out_drive_r[DutyW-1:0]))
    else $error("forward duty does not match drive");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drive_r <= 16'sd25600) && (out_drive_r >= -16'sd25600))
    else $error("drive outside +/-100 percent");

  a_target_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_idx == CFG_TARGET)) |=> (error_integral_r == '0) && (prev_err_r == '0))
    else $error("target write did not clear integral");

endmodule

`default_nettype wire

// ----- bench/motor_speed_pid_controller_top_tb.sv -----
`default_nettype none

module motor_speed_pid_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam int RandomRates   = 1950;
  localparam int SettleCycles  = 24;
  localparam int LongHold      = 300;
  localparam int WatchdogLimit = 2000;
  localparam logic signed [EncW-1:0]    EncMax    = EncW'((1 << (EncW - 1)) - 1);
  localparam logic signed [EncW-1:0]    EncMin    = EncW'(-(1 << (EncW - 1)));
  localparam logic signed [TargetW-1:0] TargetMax = TargetW'((1 << (TargetW - 1)) - 1);
  localparam logic signed [TargetW-1:0] TargetMin = TargetW'(-(1 << (TargetW - 1)));

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_THIRDS
  } stall_mode_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive_q8;
    logic        [DutyW-1:0]  duty_fwd_q8;
    logic        [DutyW-1:0]  duty_rev_q8;
  } drive_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CfgIdxW-1:0]    cfg_idx;
  logic [CfgDataW-1:0]   cfg_data;

  msp_in_if  in_chan ();
  msp_out_if out_chan ();

  motor_speed_pid_controller_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Controller copy: registers
  logic signed [TargetW-1:0] tgt_rate;
  logic        [GainW-1:0]   kp, ki, kd, int_limit;
  // Controller copy: loop state
  logic signed [IntW-1:0]    err_int;
  logic signed [ErrW-1:0]    last_err;
  logic signed [DerW-1:0]    deriv_filt;
  logic signed [DriveW-1:0]  last_drive;

  logic signed [EncW-1:0] rate_q[$];
  drive_word_t            drive_words_due[$];
  int                     rates_queued;
  int                     rates_taken;
  int                     bad_words;
  int                     quiet_cycles;
  logic                   in_taken;

  // Sender burst/gap state
  int burst_left;
  int gap_left;

  // Receiver stall state
  stall_mode_t stall_mode;
  int          mode_left;
  int          hold_req;
  int          hold_ack;
  int          hold_left;

  // One control tick; returns 0 when the target is zero (no word, no update)
  function automatic bit pid_drive_step(input logic signed [EncW-1:0] enc,
                                        output drive_word_t w);
    longint err, acc, lim, dif, der, pid, lo, hi, q8, mix, mag, drv;
    w = '0;
    if (tgt_rate == 0) return 1'b0;
    err = longint'(tgt_rate) + longint'(enc);
    lim = longint'(int_limit);

    // integral held on the target's side of zero
    acc = longint'(err_int) + err;
    if (tgt_rate > 0) begin
      if (acc < 0) acc = 0;
      else if (acc > lim) acc = lim;
    end else begin
      if (acc < -lim) acc = -lim;
      else if (acc > 0) acc = 0;
    end
    err_int = acc[IntW-1:0];

    // derivative, 0.9 new / 0.1 old, truncated
    dif = err - longint'(last_err);
    der = (9 * dif + longint'(deriv_filt)) / 10;
    deriv_filt = der[DerW-1:0];

    // Q.16 sum clamped to the drive band
    pid = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * der;
    if (tgt_rate > 0) begin
      lo = longint'(DeadbandPercent) <<< 16;
      hi = longint'(FullPercent) <<< 16;
    end else begin
      lo = -(longint'(FullPercent) <<< 16);
      hi = -(longint'(DeadbandPercent) <<< 16);
    end
    if (pid < lo) pid = lo;
    else if (pid > hi) pid = hi;
    q8 = pid / 256;

    // 0.7 old / 0.3 new, halves away from zero
    mix = 7 * longint'(last_drive) + 3 * q8;
    mag = ((mix < 0 ? -mix : mix) + 5) / 10;
    drv = mix < 0 ? -mag : mag;
    last_drive = drv[DriveW-1:0];
    last_err   = err[ErrW-1:0];

    w.drive_q8    = drv[DriveW-1:0];
    w.duty_fwd_q8 = drv > 0 ? drv[DutyW-1:0] : '0;
    w.duty_rev_q8 = drv < 0 ? mag[DutyW-1:0] : '0;
    return 1'b1;
  endfunction

  function automatic logic signed [TargetW-1:0] rand_target();
    logic signed [TargetW-1:0] t;
    case ($urandom_range(0, 9))
      0: t = TargetMax;
      1: t = TargetMin;
      2: t = '0;
      3: t = $urandom_range(0, 1) ? TargetW'(1) : TargetW'(-1);
      default: begin
        t = TargetW'($urandom_range(1, (1 << $urandom_range(1, TargetW - 1)) - 1));
        if ($urandom_range(0, 1)) t = -t;
      end
    endcase
    return t;
  endfunction

  // gains and limit: zero, full scale, or log-spread magnitude
  function automatic logic [GainW-1:0] rand_unsigned24();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return GainW'($urandom_range(0, (1 << $urandom_range(1, GainW)) - 1));
    endcase
  endfunction

  // mostly near the target (small error), now and then anything
  function automatic logic signed [EncW-1:0] rand_rate(input int span);
    longint v;
    if ($urandom_range(0, 6) == 0) return EncW'($urandom);
    v = -longint'(tgt_rate) + longint'($urandom_range(0, 2 * span)) - span;
    if (v > EncMax) v = EncMax;
    else if (v < EncMin) v = EncMin;
    return v[EncW-1:0];
  endfunction

  task automatic queue_word(input logic signed [EncW-1:0] rate);
    rate_q.push_back(rate);
    rates_queued++;
  endtask

  // register write, mirrored into the controller copy (block is idle)
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_TARGET: begin
        tgt_rate = val[TargetW-1:0];
        err_int  = '0;
        last_err = '0;
      end
      CFG_GAIN_P:    kp = val[GainW-1:0];
      CFG_GAIN_I:    ki = val[GainW-1:0];
      CFG_GAIN_D:    kd = val[GainW-1:0];
      CFG_INT_LIMIT: int_limit = val[GainW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_target(input logic signed [TargetW-1:0] t);
    write_reg(CFG_TARGET, {{(CfgDataW - TargetW){t[TargetW-1]}}, t});
  endtask

  // all words taken, all drive words back, then let a zero-target word finish
  task automatic wait_idle();
    do @(negedge clk);
    while (rates_taken != rates_queued || drive_words_due.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sender: bursts and gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        in_chan.valid <= 1'b0;
      end else if (rate_q.size() != 0) begin
        in_chan.valid        <= 1'b1;
        in_chan.encoder_rate <= rate_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern plus an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack       <= hold_req;
      hold_left      <= LongHold;
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:   out_chan.ready <= 1'b1;
        STALL_COIN:   out_chan.ready <= 1'($urandom_range(0, 1));
        STALL_HEAVY:  out_chan.ready <= ($urandom_range(0, 7) == 0);
        STALL_THIRDS: out_chan.ready <= (mode_left % 3 == 0);
        default:      out_chan.ready <= 1'b1;
      endcase
    end
  end

  // Monitor: predict on each taken word, check each drive word
  always @(posedge clk) begin : monitor
    drive_word_t want;
    drive_word_t next_w;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        rates_taken <= rates_taken + 1;
        if (pid_drive_step(in_chan.encoder_rate, next_w)) drive_words_due.push_back(next_w);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (drive_words_due.size() == 0) begin
          $display("%0t: unexpected drive word: drive %0d fwd %0d rev %0d", $time,
                   $signed(out_chan.drive_q8), out_chan.duty_fwd_q8, out_chan.duty_rev_q8);
          bad_words++;
        end else begin
          want = drive_words_due.pop_front();
          if (out_chan.drive_q8 !== want.drive_q8) begin
            $display("%0t: drive_q8 expected %0d got %0d", $time,
                     $signed(want.drive_q8), $signed(out_chan.drive_q8));
            bad_words++;
          end
          if (out_chan.duty_fwd_q8 !== want.duty_fwd_q8) begin
            $display("%0t: duty_fwd_q8 expected %0d got %0d", $time,
                     want.duty_fwd_q8, out_chan.duty_fwd_q8);
            bad_words++;
          end
          if (out_chan.duty_rev_q8 !== want.duty_rev_q8) begin
            $display("%0t: duty_rev_q8 expected %0d got %0d", $time,
                     want.duty_rev_q8, out_chan.duty_rev_q8);
            bad_words++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any word moving
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int p_drive;
    int span;
    int count;
    int phase;
    logic [CfgIdxW-1:0] spare;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.encoder_rate = '0;
    out_chan.ready = 1'b0;
    in_taken = 1'b0;
    rates_queued = 0;
    rates_taken = 0;
    bad_words = 0;
    quiet_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = STALL_NONE;
    mode_left = 0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    tgt_rate = '0;
    kp = '0;
    ki = '0;
    kd = '0;
    int_limit = IntLimitReset;
    err_int = '0;
    last_err = '0;
    deriv_filt = '0;
    last_drive = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // zero target after reset: words are swallowed
    @(posedge clk);
    queue_word(EncMax);
    queue_word(EncMin);
    wait_idle();

    // band floor with zero gains: drive ramps toward 40 percent
    write_target(1);
    @(posedge clk);
    queue_word(EncMax);
    queue_word(EncMin);
    wait_idle();

    // sign change with a gain picked so 0.7 old + 0.3 new lands on zero drive
    p_drive = last_drive;
    write_target(-1);
    write_reg(CFG_GAIN_P, GainW'((7 * p_drive + 1) / 3));
    @(posedge clk);
    queue_word(-255);
    queue_word(0);
    queue_word(-1);
    wait_idle();

    // full-scale gains and target, widest limit
    write_reg(CFG_GAIN_P, '1);
    write_reg(CFG_GAIN_I, '1);
    write_reg(CFG_GAIN_D, '1);
    write_reg(CFG_INT_LIMIT, '1);
    write_target(TargetMax);
    @(posedge clk);
    queue_word(EncMax);
    queue_word(EncMin);
    queue_word(0);
    queue_word(-1);
    queue_word(1);
    wait_idle();

    // most negative target, integral pinned at zero; drive crosses the band
    write_reg(CFG_INT_LIMIT, '0);
    write_target(TargetMin);
    @(posedge clk);
    queue_word(EncMax);
    queue_word(EncMin);
    queue_word(0);
    wait_idle();

    // moderate gains, unsaturated sum
    write_reg(CFG_GAIN_P, GainW'(65536));
    write_reg(CFG_GAIN_I, GainW'(256));
    write_reg(CFG_GAIN_D, GainW'(4096));
    write_reg(CFG_INT_LIMIT, GainW'(1000));
    write_target(300);
    @(posedge clk);
    queue_word(-300);
    queue_word(-290);
    queue_word(-310);
    queue_word(-250);

    // random phases
    phase = 0;
    while (rates_queued < RandomRates) begin
      wait_idle();
      if (phase == 0 || $urandom_range(0, 3) != 0) write_target(rand_target());
      if (phase == 0 || $urandom_range(0, 1)) write_reg(CFG_GAIN_P, rand_unsigned24());
      if (phase == 0 || $urandom_range(0, 1)) write_reg(CFG_GAIN_I, rand_unsigned24());
      if (phase == 0 || $urandom_range(0, 1)) write_reg(CFG_GAIN_D, rand_unsigned24());
      if (phase == 0 || $urandom_range(0, 1)) write_reg(CFG_INT_LIMIT, rand_unsigned24());
      if ($urandom_range(0, 7) == 0) begin
        spare = CFG_INT_LIMIT + CfgIdxW'($urandom_range(1, 3));
        write_reg(spare, CfgDataW'($urandom));
      end
      // make sure the long hold-off runs against a live target
      if (phase % 12 == 3 && tgt_rate == 0) write_target(TargetW'(500));
      span  = 1 << $urandom_range(0, 20);
      count = $urandom_range(20, 80);
      @(posedge clk);
      repeat (count) queue_word(rand_rate(span));
      if (phase % 12 == 3) hold_req <= hold_req + 1;
      phase++;
    end
    wait_idle();

    if (bad_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
